### sv/lsh_pkg.sv
// Shared types and constants for the 3x3 Laplacian sharpening block.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package lsh_pkg;

  localparam int unsigned CH_BITS    = 8;
  localparam int unsigned NCH        = 4;
  localparam int unsigned PIX_BITS   = CH_BITS * NCH;
  localparam int unsigned SUM_BITS   = CH_BITS + 2;
  localparam int unsigned TOT_BITS   = CH_BITS + 4;
  localparam int unsigned STR_BITS   = 20;
  localparam int unsigned DIM_BITS   = 13;
  localparam int unsigned ROW_BITS   = 12;
  localparam int unsigned ROW_LIMIT  = 4096;
  localparam int unsigned ROUND_BIAS = 256 * 4;
  localparam int unsigned SHIFT_BITS = 8 + 3;
  localparam int unsigned CFG_IDX_BITS = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_STRENGTH = 2'd0,
    REG_WIDTH    = 2'd1,
    REG_HEIGHT   = 2'd2
  } cfg_idx_e;

  typedef logic [NCH-1:0][CH_BITS-1:0] pix_t;

  // One classified input pixel with the line store data it needs.
  typedef struct packed {
    logic d_en;
    logic d_load;
    logic d_last;
    logic pass;
    logic m_en;
    logic m_load;
    logic m_top_mid;
    logic m_row_end;
    logic last;
    pix_t pix;
    pix_t up_c;
    pix_t mid_c;
    pix_t up_f;
    pix_t mid_f;
  } job_t;

endpackage
`default_nettype wire

### sv/lsh_if.sv
// Valid/ready stream interfaces for input pixels and sharpened results.
// Depends on lsh_pkg for the channel width.
`timescale 1ns / 1ps
`default_nettype none
interface lsh_pix_if;
  logic                       valid;
  logic                       ready;
  logic [lsh_pkg::CH_BITS-1:0] red_in;
  logic [lsh_pkg::CH_BITS-1:0] green_in;
  logic [lsh_pkg::CH_BITS-1:0] blue_in;
  logic [lsh_pkg::CH_BITS-1:0] matte_in;
  modport source(output valid, red_in, green_in, blue_in, matte_in, input ready);
  modport sink(input valid, red_in, green_in, blue_in, matte_in, output ready);
endinterface

interface lsh_res_if;
  logic                       valid;
  logic                       ready;
  logic [lsh_pkg::CH_BITS-1:0] red_out;
  logic [lsh_pkg::CH_BITS-1:0] green_out;
  logic [lsh_pkg::CH_BITS-1:0] blue_out;
  logic [lsh_pkg::CH_BITS-1:0] matte_out;
  logic                       frame_last;
  modport source(output valid, red_out, green_out, blue_out, matte_out, frame_last,
                 input ready);
  modport sink(input valid, red_out, green_out, blue_out, matte_out, frame_last,
               output ready);
endinterface
`default_nettype wire

### sv/lsh_front.sv
// Front end: accepts pixels, keeps raster counters and drain state, owns the
// two line stores and emits classified jobs. Depends on lsh_pkg, lsh_if.
`timescale 1ns / 1ps
`default_nettype none
module lsh_front #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  lsh_pix_if.sink                           pix_i,
  input  wire  [lsh_pkg::DIM_BITS-1:0]      frame_width_i,
  input  wire  [lsh_pkg::DIM_BITS-1:0]      frame_height_i,
  output lsh_pkg::job_t                     job_o,
  output logic                              job_valid_o,
  input  wire                               job_ready_i
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned DB = lsh_pkg::DIM_BITS;

  lsh_pkg::pix_t up_mem  [MAX_WIDTH];
  lsh_pkg::pix_t mid_mem [MAX_WIDTH];

  logic [AW-1:0]                 col_q, col_d;
  logic [lsh_pkg::ROW_BITS-1:0]  row_q, row_d;
  logic                          drain_q, drain_d;
  logic [AW-1:0]                 dcol_q, dcol_d;
  logic [CW-1:0]                 dw_q, dw_d;

  logic                          s1_valid_q;
  logic                          s1_wr_q;
  logic [AW-1:0]                 s1_addr_q;
  lsh_pkg::job_t                 s1_job_q;
  lsh_pkg::pix_t                 up_c_q, mid_c_q, up_f_q, mid_f_q;

  logic [CW-1:0]                 eff_w;
  logic [DB-1:0]                 eff_h;
  logic                          accept, wr_fire, row_end, frame_end, pass, d_last;
  lsh_pkg::pix_t                 pix;

  assign pix = {pix_i.matte_in, pix_i.blue_in, pix_i.green_in, pix_i.red_in};
  assign pix_i.ready = !s1_valid_q || job_ready_i;
  assign accept  = pix_i.valid && pix_i.ready;
  assign wr_fire = s1_valid_q && job_ready_i && s1_wr_q;

  always_comb begin
    if (frame_width_i == '0) begin
      eff_w = CW'(1);
    end else if (32'(frame_width_i) > MAX_WIDTH) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = CW'(frame_width_i);
    end
    if (frame_height_i == '0) begin
      eff_h = DB'(1);
    end else if (32'(frame_height_i) > lsh_pkg::ROW_LIMIT) begin
      eff_h = DB'(lsh_pkg::ROW_LIMIT);
    end else begin
      eff_h = frame_height_i;
    end
  end

  assign row_end   = ({1'b0, col_q} + CW'(1)) >= eff_w;
  assign frame_end = row_end && (({1'b0, row_q} + DB'(1)) >= eff_h);
  assign pass      = (eff_w == CW'(1)) || (eff_h == DB'(1));
  assign d_last    = ({1'b0, dcol_q} + CW'(1)) >= dw_q;

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    drain_d = drain_q;
    dcol_d  = dcol_q;
    dw_d    = dw_q;
    if (accept) begin
      if (drain_q) begin
        if (d_last) begin
          drain_d = 1'b0;
        end else begin
          dcol_d = dcol_q + AW'(1);
        end
      end
      if (!pass && frame_end) begin
        drain_d = 1'b1;
        dcol_d  = '0;
        dw_d    = eff_w;
      end
      if (row_end) begin
        col_d = '0;
        row_d = frame_end ? '0 : row_q + lsh_pkg::ROW_BITS'(1);
      end else begin
        col_d = col_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      drain_q    <= 1'b0;
      dcol_q     <= '0;
      dw_q       <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      drain_q <= drain_d;
      dcol_q  <= dcol_d;
      dw_q    <= dw_d;
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (job_ready_i) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // Line stores: the write of the previous pixel lands at the same edge as
  // the next reads, so reads forward the pending write.
  always_ff @(posedge clk_i) begin
    if (wr_fire) begin
      up_mem[s1_addr_q]  <= mid_c_q;
      mid_mem[s1_addr_q] <= s1_job_q.pix;
    end
    if (accept) begin
      if (wr_fire && s1_addr_q == col_q) begin
        up_c_q  <= mid_c_q;
        mid_c_q <= s1_job_q.pix;
      end else begin
        up_c_q  <= up_mem[col_q];
        mid_c_q <= mid_mem[col_q];
      end
      if (wr_fire && s1_addr_q == dcol_q) begin
        up_f_q  <= mid_c_q;
        mid_f_q <= s1_job_q.pix;
      end else begin
        up_f_q  <= up_mem[dcol_q];
        mid_f_q <= mid_mem[dcol_q];
      end
      s1_wr_q             <= !pass;
      s1_addr_q           <= col_q;
      s1_job_q.d_en       <= drain_q;
      s1_job_q.d_load     <= dcol_q == '0;
      s1_job_q.d_last     <= d_last;
      s1_job_q.pass       <= pass;
      s1_job_q.m_en       <= !pass && row_q != '0;
      s1_job_q.m_load     <= col_q == '0;
      s1_job_q.m_top_mid  <= row_q == lsh_pkg::ROW_BITS'(1);
      s1_job_q.m_row_end  <= row_end;
      s1_job_q.last       <= frame_end;
      s1_job_q.pix        <= pix;
      s1_job_q.up_c       <= '0;
      s1_job_q.mid_c      <= '0;
      s1_job_q.up_f       <= '0;
      s1_job_q.mid_f      <= '0;
    end
  end

  always_comb begin
    job_o       = s1_job_q;
    job_o.up_c  = up_c_q;
    job_o.mid_c = mid_c_q;
    job_o.up_f  = up_f_q;
    job_o.mid_f = mid_f_q;
  end
  assign job_valid_o = s1_valid_q;

`ifndef SYNTHESIS
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(col_q) < MAX_WIDTH)
    else $error("column counter beyond line store");
  a_drain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_q |-> ({1'b0, dcol_q} < dw_q))
    else $error("drain column beyond drained width");
`endif

endmodule
`default_nettype wire

### sv/lsh_queue.sv
// Short job queue between front and back end.
// Depends on lsh_pkg for the job type.
`timescale 1ns / 1ps
`default_nettype none
module lsh_queue (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  lsh_pkg::job_t  job_i,
  input  wire            valid_i,
  output logic           ready_o,
  output lsh_pkg::job_t  job_o,
  output logic           valid_o,
  input  wire            ready_i
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PW    = $clog2(DEPTH);

  lsh_pkg::job_t   mem_q [DEPTH];
  logic [PW-1:0]   wp_q, rp_q;
  logic [PW:0]     cnt_q;
  logic            push, pop;

  assign ready_o = cnt_q != (PW+1)'(DEPTH);
  assign valid_o = cnt_q != '0;
  assign push    = valid_i && ready_o;
  assign pop     = valid_o && ready_i;
  assign job_o   = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wp_q <= wp_q + PW'(1);
      end
      if (pop) begin
        rp_q <= rp_q + PW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + (PW+1)'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - (PW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= job_i;
    end
  end

`ifndef SYNTHESIS
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PW+1)'(DEPTH))
    else $error("job queue overfilled");
`endif

endmodule
`default_nettype wire

### sv/lsh_back.sv
// Back end: steps the main and drain windows through each job's phases and
// runs the sharpen arithmetic pipeline to the result port. Depends on lsh_pkg, lsh_if.
`timescale 1ns / 1ps
`default_nettype none
module lsh_back (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  lsh_pkg::job_t                  job_i,
  input  wire                            job_valid_i,
  output logic                           job_ready_o,
  input  wire  [lsh_pkg::STR_BITS-1:0]   strength_i,
  lsh_res_if.source                      res_o
);

  localparam int unsigned N  = lsh_pkg::NCH;
  localparam int unsigned CB = lsh_pkg::CH_BITS;
  localparam int unsigned SB = lsh_pkg::SUM_BITS;
  localparam int unsigned TB = lsh_pkg::TOT_BITS;
  localparam int unsigned PB = TB + lsh_pkg::STR_BITS;

  typedef struct packed {
    logic [N-1:0][SB-1:0] west;
    logic [N-1:0][SB-1:0] mid;
    logic [N-1:0][SB-1:0] east;
    lsh_pkg::pix_t        cpix;
    lsh_pkg::pix_t        epix;
  } win_t;

  typedef enum logic [1:0] {PH_DSTEP, PH_DTAIL, PH_MSTEP, PH_MTAIL} phase_e;
  typedef enum logic [1:0] {OP_NONE, OP_LOAD, OP_PUSH, OP_TAIL} op_e;

  win_t                 dwin_q, mwin_q, wsel, wnew;
  logic [3:0]           mask, pend, done_q, bit_sel;
  phase_e               ph;
  op_e                  op;
  logic [N-1:0][SB-1:0] s_d, s_m, s_sel;
  lsh_pkg::pix_t        p_sel;
  logic                 emit, emit_last, fire, finish;

  logic                       a_v_q, a_pass_q, a_last_q;
  logic [N-1:0][CB-1:0]       a_c_q;
  logic [N-1:0][TB-1:0]       a_tot_q;
  logic                       b_v_q, b_pass_q, b_last_q;
  logic [N-1:0][CB-1:0]       b_c_q;
  logic [N-1:0][PB-1:0]       b_prod_q;
  logic [N-1:0]               b_neg_q;
  logic                       o_v_q, o_last_q;
  lsh_pkg::pix_t              o_pix_q;
  logic                       o_adv, b_adv, a_free;

  assign o_adv  = !o_v_q || res_o.ready;
  assign b_adv  = !b_v_q || o_adv;
  assign a_free = !a_v_q || b_adv;

  assign mask = {job_i.m_en && job_i.m_row_end, job_i.m_en || job_i.pass,
                 job_i.d_en && job_i.d_last, job_i.d_en};
  assign pend = mask & ~done_q;

  always_comb begin
    priority if (pend[0]) begin
      ph = PH_DSTEP;
    end else if (pend[1]) begin
      ph = PH_DTAIL;
    end else if (pend[2]) begin
      ph = PH_MSTEP;
    end else begin
      ph = PH_MTAIL;
    end
    bit_sel = 4'b0001 << ph;
  end

  always_comb begin
    for (int ch = 0; ch < N; ch++) begin
      s_d[ch] = SB'(job_i.up_f[ch]) + {1'b0, job_i.mid_f[ch], 1'b0};
      s_m[ch] = SB'(job_i.m_top_mid ? job_i.mid_c[ch] : job_i.up_c[ch])
              + SB'(job_i.mid_c[ch]) + SB'(job_i.pix[ch]);
    end
  end

  always_comb begin
    op        = OP_NONE;
    emit      = 1'b0;
    emit_last = 1'b0;
    wsel      = mwin_q;
    s_sel     = s_m;
    p_sel     = job_i.mid_c;
    unique case (ph)
      PH_DSTEP: begin
        wsel  = dwin_q;
        s_sel = s_d;
        p_sel = job_i.mid_f;
        op    = job_i.d_load ? OP_LOAD : OP_PUSH;
        emit  = !job_i.d_load;
      end
      PH_DTAIL: begin
        wsel      = dwin_q;
        op        = OP_TAIL;
        emit      = 1'b1;
        emit_last = 1'b1;
      end
      PH_MSTEP: begin
        if (job_i.pass) begin
          emit      = 1'b1;
          emit_last = job_i.last;
        end else begin
          op   = job_i.m_load ? OP_LOAD : OP_PUSH;
          emit = !job_i.m_load;
        end
      end
      PH_MTAIL: begin
        op   = OP_TAIL;
        emit = 1'b1;
      end
      default: begin
        op = OP_NONE;
      end
    endcase
  end

  always_comb begin
    wnew = wsel;
    unique case (op)
      OP_LOAD: begin
        wnew.west = s_sel;
        wnew.mid  = s_sel;
        wnew.east = s_sel;
        wnew.epix = p_sel;
      end
      OP_PUSH: begin
        wnew.cpix = wsel.epix;
        wnew.epix = p_sel;
        wnew.west = wsel.mid;
        wnew.mid  = wsel.east;
        wnew.east = s_sel;
      end
      OP_TAIL: begin
        wnew.cpix = wsel.epix;
        wnew.west = wsel.mid;
        wnew.mid  = wsel.east;
      end
      default: begin
        wnew = wsel;
      end
    endcase
  end

  assign fire        = job_valid_i && a_free;
  assign finish      = (pend & ~bit_sel) == '0;
  assign job_ready_o = fire && finish;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dwin_q <= '0;
      mwin_q <= '0;
      done_q <= '0;
      a_v_q  <= 1'b0;
      b_v_q  <= 1'b0;
      o_v_q  <= 1'b0;
    end else begin
      if (fire && pend != '0) begin
        if (ph == PH_DSTEP || ph == PH_DTAIL) begin
          dwin_q <= wnew;
        end else begin
          mwin_q <= wnew;
        end
      end
      if (fire) begin
        done_q <= finish ? '0 : (done_q | bit_sel);
      end
      if (a_free) begin
        a_v_q <= fire && pend != '0 && emit;
      end
      if (b_adv) begin
        b_v_q <= a_v_q;
      end
      if (o_adv) begin
        o_v_q <= b_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_free) begin
      a_pass_q <= ph == PH_MSTEP && job_i.pass;
      a_last_q <= emit_last;
      for (int ch = 0; ch < N; ch++) begin
        a_c_q[ch]   <= (ph == PH_MSTEP && job_i.pass) ? job_i.pix[ch] : wnew.cpix[ch];
        a_tot_q[ch] <= TB'(wnew.west[ch]) + TB'(wnew.mid[ch]) + TB'(wnew.east[ch]);
      end
    end
  end

  logic [N-1:0][TB-1:0] nine, diff;
  always_comb begin
    for (int ch = 0; ch < N; ch++) begin
      nine[ch] = {1'b0, a_c_q[ch], 3'b000} + TB'(a_c_q[ch]);
      diff[ch] = (nine[ch] < a_tot_q[ch]) ? a_tot_q[ch] - nine[ch] : nine[ch] - a_tot_q[ch];
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      b_pass_q <= a_pass_q;
      b_last_q <= a_last_q;
      b_c_q    <= a_c_q;
      for (int ch = 0; ch < N; ch++) begin
        b_neg_q[ch]  <= nine[ch] < a_tot_q[ch];
        b_prod_q[ch] <= PB'(diff[ch]) * PB'(strength_i);
      end
    end
  end

  logic [N-1:0][PB:0] rnd;
  logic [N-1:0][PB-lsh_pkg::SHIFT_BITS:0] t;
  logic [N-1:0][PB-lsh_pkg::SHIFT_BITS+1:0] v;
  lsh_pkg::pix_t res;
  always_comb begin
    for (int ch = 0; ch < N; ch++) begin
      rnd[ch] = (PB+1)'(lsh_pkg::ROUND_BIAS) + (PB+1)'(b_prod_q[ch]);
      t[ch] = rnd[ch][PB:lsh_pkg::SHIFT_BITS];
      v[ch] = (PB-lsh_pkg::SHIFT_BITS+2)'(t[ch]) + (PB-lsh_pkg::SHIFT_BITS+2)'(b_c_q[ch]);
      if (b_pass_q) begin
        res[ch] = b_c_q[ch];
      end else if (b_neg_q[ch]) begin
        res[ch] = (t[ch] >= (PB-lsh_pkg::SHIFT_BITS+1)'(b_c_q[ch])) ? '0
                : b_c_q[ch] - CB'(t[ch]);
      end else begin
        res[ch] = (v[ch] >= (PB-lsh_pkg::SHIFT_BITS+2)'({CB{1'b1}})) ? {CB{1'b1}}
                : CB'(v[ch]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_adv) begin
      o_pix_q  <= res;
      o_last_q <= b_last_q;
    end
  end

  assign res_o.valid      = o_v_q;
  assign res_o.red_out    = o_pix_q[0];
  assign res_o.green_out  = o_pix_q[1];
  assign res_o.blue_out   = o_pix_q[2];
  assign res_o.matte_out  = o_pix_q[3];
  assign res_o.frame_last = o_last_q;

`ifndef SYNTHESIS
  a_done_in_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_i |-> ((done_q & ~mask) == '0))
    else $error("completed phase outside the job's phase set");
`endif

endmodule
`default_nettype wire

### sv/laplacian_sharpen_3x3.sv
// Top level of the 3x3 Laplacian sharpening filter: configuration registers,
// front end, job queue and back end. Depends on lsh_pkg, lsh_if and submodules.
//
// Takes one RGBM pixel per clock in raster order and returns sharpened pixels
// one per clock while neither side stalls, delayed by one row plus one pixel;
// a result passes the front-end job register, the job queue and the back-end
// stages a, b and output in turn, after any earlier result of the same pixel.
// Most inputs yield one result; at a
// row end, and while the last row of the previous frame is drained alongside
// new input, one input yields up to four, and the single result port then
// sets the rate: the back end spends one cycle per result, the four-entry job
// queue absorbs the burst and the input stalls only when it is full. The last
// row of a frame appears only as further pixels arrive. Frames of width or
// height 1 pass through. Line stores are two single-write, dual-read memories
// of MAX_WIDTH pixels each; they need no clearing after reset.
`timescale 1ns / 1ps
`default_nettype none
module laplacian_sharpen_3x3 #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  lsh_pix_if.sink                            pix_i,
  lsh_res_if.source                          res_o,
  input  wire                                cfg_we_i,
  input  wire  [lsh_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  wire  [lsh_pkg::STR_BITS-1:0]       cfg_data_i
);

  logic [lsh_pkg::STR_BITS-1:0] strength_q;
  logic [lsh_pkg::DIM_BITS-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strength_q <= lsh_pkg::STR_BITS'(50);
      width_q    <= lsh_pkg::DIM_BITS'(4096);
      height_q   <= lsh_pkg::DIM_BITS'(4096);
    end else if (cfg_we_i) begin
      unique case (lsh_pkg::cfg_idx_e'(cfg_idx_i))
        lsh_pkg::REG_STRENGTH: strength_q <= cfg_data_i;
        lsh_pkg::REG_WIDTH:    width_q    <= cfg_data_i[lsh_pkg::DIM_BITS-1:0];
        lsh_pkg::REG_HEIGHT:   height_q   <= cfg_data_i[lsh_pkg::DIM_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  lsh_pkg::job_t fe_job, q_job;
  logic          fe_valid, fe_ready, q_valid, q_ready;

  lsh_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pix_i          (pix_i),
    .frame_width_i  (width_q),
    .frame_height_i (height_q),
    .job_o          (fe_job),
    .job_valid_o    (fe_valid),
    .job_ready_i    (fe_ready)
  );

  lsh_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .job_i   (fe_job),
    .valid_i (fe_valid),
    .ready_o (fe_ready),
    .job_o   (q_job),
    .valid_o (q_valid),
    .ready_i (q_ready)
  );

  lsh_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (q_job),
    .job_valid_i (q_valid),
    .job_ready_o (q_ready),
    .strength_i  (strength_q),
    .res_o       (res_o)
  );

endmodule
`default_nettype wire

### bench/tb.sv
// Self-checking bench for laplacian_sharpen_3x3: random valid/ready pixel traffic,
// register phases between frames, scoreboard with its own sharpening predictor.
// Depends on lsh_pkg, lsh_if and the laplacian_sharpen_3x3 RTL.
`timescale 1ns / 1ps

typedef struct packed {
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] matte;
  logic       last;
} px_res_t;

typedef struct packed {
  logic [3:0][11:0] west;
  logic [3:0][11:0] mid;
  logic [3:0][11:0] east;
  logic [3:0][7:0]  cpix;
  logic [3:0][7:0]  epix;
} win3_t;

class sharpen_scoreboard;
  logic [7:0] upper_row[4096][4];
  logic [7:0] middle_row[4096][4];
  win3_t      main_win, drain_win;
  int unsigned col_cnt, row_cnt;
  bit          drain_on;
  int unsigned drain_col, drain_wid;
  int unsigned strength, width, height;
  px_res_t     expected_px[$];
  int unsigned mismatches;

  function new();
    main_win = '0;
    drain_win = '0;
    col_cnt = 0;
    row_cnt = 0;
    drain_on = 0;
    drain_col = 0;
    drain_wid = 0;
    strength = 50;
    width = 4096;
    height = 4096;
    mismatches = 0;
  endfunction

  function int pending();
    return expected_px.size();
  endfunction

  function logic [7:0] sharpen(int unsigned c, int unsigned total);
    longint unsigned nine, t, v;
    nine = 9 * c;
    if (nine < total) begin
      t = (64'd1024 + (total - nine) * longint'(strength)) >> 11;
      return (t >= c) ? 8'd0 : 8'(c - t);
    end
    v = c + ((64'd1024 + (nine - total) * longint'(strength)) >> 11);
    return (v >= 255) ? 8'd255 : 8'(v);
  endfunction

  function void emit(win3_t w, logic last);
    logic [3:0][7:0] o;
    for (int ch = 0; ch < 4; ch++) begin
      o[ch] = sharpen(w.cpix[ch], w.west[ch] + w.mid[ch] + w.east[ch]);
    end
    expected_px.push_back('{o[0], o[1], o[2], o[3], last});
  endfunction

  function win3_t win_load(logic [3:0][11:0] s, logic [3:0][7:0] p, win3_t w);
    w.west = s;
    w.mid  = s;
    w.east = s;
    w.epix = p;
    return w;
  endfunction

  function win3_t win_push(win3_t w, logic [3:0][11:0] s, logic [3:0][7:0] p);
    w.cpix = w.epix;
    w.epix = p;
    w.west = w.mid;
    w.mid  = w.east;
    w.east = s;
    return w;
  endfunction

  function win3_t win_tail(win3_t w);
    w.cpix = w.epix;
    w.west = w.mid;
    w.mid  = w.east;
    return w;
  endfunction

  function void set_reg(lsh_pkg::cfg_idx_e idx, int unsigned val);
    case (idx)
      lsh_pkg::REG_STRENGTH: strength = val & 32'hFFFFF;
      lsh_pkg::REG_WIDTH:    width = val & 32'h1FFF;
      lsh_pkg::REG_HEIGHT:   height = val & 32'h1FFF;
      default: ;
    endcase
  endfunction

  function void note_input(logic [3:0][7:0] p);
    int unsigned w, h, c, r, f;
    logic [3:0][11:0] s;
    logic [3:0][7:0] dp;
    bit row_end, frame_end;
    w = (width == 0) ? 1 : (width > 4096 ? 4096 : width);
    h = (height == 0) ? 1 : (height > 4096 ? 4096 : height);
    if (drain_on) begin
      f = drain_col % 4096;
      for (int ch = 0; ch < 4; ch++) begin
        dp[ch] = middle_row[f][ch];
        s[ch] = upper_row[f][ch] + 2 * dp[ch];
      end
      if (f == 0) begin
        drain_win = win_load(s, dp, drain_win);
      end else begin
        drain_win = win_push(drain_win, s, dp);
        emit(drain_win, 1'b0);
      end
      if (f + 1 >= drain_wid) begin
        drain_win = win_tail(drain_win);
        emit(drain_win, 1'b1);
        drain_on = 0;
      end else begin
        drain_col = f + 1;
      end
    end
    c = col_cnt % 4096;
    r = row_cnt;
    row_end = (c + 1 >= w);
    frame_end = row_end && (r + 1 >= h);
    if (w == 1 || h == 1) begin
      expected_px.push_back('{p[0], p[1], p[2], p[3], frame_end});
    end else begin
      if (r >= 1) begin
        for (int ch = 0; ch < 4; ch++) begin
          dp[ch] = middle_row[c][ch];
          s[ch] = ((r == 1) ? middle_row[c][ch] : upper_row[c][ch]) + dp[ch] + p[ch];
        end
        if (c == 0) begin
          main_win = win_load(s, dp, main_win);
        end else begin
          main_win = win_push(main_win, s, dp);
          emit(main_win, 1'b0);
        end
        if (row_end) begin
          main_win = win_tail(main_win);
          emit(main_win, 1'b0);
        end
      end
      for (int ch = 0; ch < 4; ch++) begin
        upper_row[c][ch] = middle_row[c][ch];
        middle_row[c][ch] = p[ch];
      end
      if (frame_end) begin
        drain_on = 1;
        drain_col = 0;
        drain_wid = w;
      end
    end
    if (row_end) begin
      col_cnt = 0;
      row_cnt = frame_end ? 0 : (r + 1) % 4096;
    end else begin
      col_cnt = c + 1;
    end
  endfunction

  function void check_result(px_res_t got);
    px_res_t exp_px;
    if (expected_px.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    exp_px = expected_px.pop_front();
    if (got !== exp_px) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch rgbm/last: expected %h %h %h %h %b, got %h %h %h %h %b",
                 exp_px.red, exp_px.green, exp_px.blue, exp_px.matte, exp_px.last,
                 got.red, got.green, got.blue, got.matte, got.last);
      end
    end
  endfunction
endclass

module tb;

  localparam int IDLE_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 20;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [lsh_pkg::CFG_IDX_BITS-1:0] cfg_idx;
  logic [lsh_pkg::STR_BITS-1:0] cfg_data;
  bit                  quiet;
  int                  items_sent;
  int                  idle_cycles;
  int                  stall_left;
  sharpen_scoreboard   sb;

  lsh_pix_if pix ();
  lsh_res_if res ();

  laplacian_sharpen_3x3 i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .pix_i      (pix),
    .res_o      (res),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function int rand_gap();
    int x;
    if (quiet) return 0;
    x = $urandom_range(0, 99);
    if (x < 60) return 0;
    if (x < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side: sample the transfer, then choose ready for the next cycle
  always @(posedge clk) begin
    if (rst_n && res.valid && res.ready) begin
      sb.check_result('{res.red_out, res.green_out, res.blue_out, res.matte_out,
                        res.frame_last});
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      stall_left <= rand_gap();
      res.ready <= 1'b0;
    end else begin
      res.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((pix.valid && pix.ready) || (res.valid && res.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic send_pixel(logic [3:0][7:0] p);
    int gap;
    gap = rand_gap();
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix.valid    <= 1'b1;
    pix.red_in   <= p[0];
    pix.green_in <= p[1];
    pix.blue_in  <= p[2];
    pix.matte_in <= p[3];
    do @(posedge clk); while (!pix.ready);
    sb.note_input(p);
    items_sent++;
  endtask

  task automatic wait_drained();
    pix.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(lsh_pkg::cfg_idx_e idx, int unsigned val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val[lsh_pkg::STR_BITS-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic set_frame(int unsigned str, int unsigned w, int unsigned h);
    wait_drained();
    write_reg(lsh_pkg::REG_STRENGTH, str);
    write_reg(lsh_pkg::REG_WIDTH, w);
    write_reg(lsh_pkg::REG_HEIGHT, h);
    @(posedge clk);
  endtask

  // mode 1 favors the channel extremes
  task automatic send_frames(int unsigned w, int unsigned h, int frames, int mode);
    logic [3:0][7:0] p;
    int n;
    n = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h) * frames;
    for (int i = 0; i < n; i++) begin
      for (int ch = 0; ch < 4; ch++) begin
        case ($urandom_range(0, mode ? 2 : 7))
          0: p[ch] = 8'd0;
          1: p[ch] = 8'd255;
          default: p[ch] = 8'($urandom);
        endcase
      end
      send_pixel(p);
    end
  endtask

  initial begin
    int unsigned str, w, h;
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    quiet = 1'b0;
    items_sent = 0;
    idle_cycles = 0;
    stall_left = 0;
    pix.valid = 1'b0;
    pix.red_in = '0;
    pix.green_in = '0;
    pix.blue_in = '0;
    pix.matte_in = '0;
    res.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_frame(999999, 3, 2);
    send_frames(3, 2, 1, 1);
    set_frame(50, 1, 3);
    send_frames(1, 3, 1, 1);
    set_frame(0, 3, 1);
    send_frames(3, 1, 1, 1);
    set_frame(1000, 0, 2);
    send_frames(0, 2, 1, 1);
    set_frame(0, 5, 2);
    send_frames(5, 2, 1, 1);
    // second frame ends before the previous last row has drained
    set_frame(2048, 2, 0);
    write_reg(lsh_pkg::REG_HEIGHT, 2);
    send_frames(2, 2, 1, 1);

    while (items_sent < 310) begin
      case ($urandom_range(0, 5))
        0: str = 0;
        1: str = 999999;
        2: str = $urandom_range(0, 4096);
        default: str = $urandom_range(0, 999999);
      endcase
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 9);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 5);
      set_frame(str, w, h);
      quiet = ($urandom_range(0, 4) == 0);
      send_frames(w, h, $urandom_range(1, 2), $urandom_range(0, 1));
    end
    quiet = 1'b0;

    wait_drained();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
